// File: hw/rtl/ldm_pkg.sv
package ldm_pkg;

  localparam int NODE_W         = 32;
  localparam int NODE_FRAC_BITS = 28;
  localparam int ENTRY_W        = 48;
  localparam int DIFF_W         = NODE_W + 1;
  localparam int PROD_W         = ENTRY_W + DIFF_W;

  localparam int NODES_DEF = 4;
  localparam int EFB_DEF   = 32;

  localparam logic [ENTRY_W-1:0] ENTRY_MAX = {1'b0, {(ENTRY_W-1){1'b1}}};
  localparam logic [ENTRY_W-1:0] ENTRY_MIN = {1'b1, {(ENTRY_W-1){1'b0}}};

  // request to the multiply-divide unit: floor(m * a / b)
  typedef struct packed {
    logic               start;
    logic [ENTRY_W-1:0] m;
    logic [DIFF_W-1:0]  a;
    logic [DIFF_W-1:0]  b;
  } md_req_t;

  typedef struct packed {
    logic               done;
    logic               ovf;
    logic [ENTRY_W-1:0] q;
  } md_rsp_t;

endpackage

// File: hw/rtl/ldm_muldiv.sv
module ldm_muldiv (
  input  logic            clk,
  input  logic            rst_n,
  input  ldm_pkg::md_req_t req,
  output ldm_pkg::md_rsp_t rsp
);
  import ldm_pkg::*;

  localparam int CW = $clog2(PROD_W + 1);

  typedef enum logic [1:0] {U_IDLE, U_MUL, U_DIV, U_FIN} ustate_t;

  ustate_t             state_r;
  logic [PROD_W-1:0]   mcand_r;
  logic [DIFF_W-1:0]   mplier_r;
  logic [PROD_W-1:0]   prod_r;
  logic [PROD_W-1:0]   quo_r;
  logic [DIFF_W-1:0]   rem_r;
  logic [DIFF_W-1:0]   div_r;
  logic [CW-1:0]       cnt_r;
  md_rsp_t             rsp_r;

  logic [DIFF_W:0]     shifted;
  logic                ge;

  assign shifted = {rem_r, prod_r[PROD_W-1]};
  assign ge      = shifted >= {1'b0, div_r};
  assign rsp     = rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= U_IDLE;
      rsp_r.done <= 1'b0;
    end else begin
      rsp_r.done <= 1'b0;
      case (state_r)
        U_IDLE: begin
          if (req.start) begin
            mcand_r  <= {{(PROD_W-ENTRY_W){1'b0}}, req.m};
            mplier_r <= req.a;
            div_r    <= req.b;
            prod_r   <= '0;
            cnt_r    <= '0;
            state_r  <= U_MUL;
          end
        end
        // shift-add multiply, one multiplier bit a cycle
        U_MUL: begin
          if (mplier_r[0]) prod_r <= prod_r + mcand_r;
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
          if (cnt_r == CW'(DIFF_W - 1)) begin
            cnt_r   <= '0;
            rem_r   <= '0;
            quo_r   <= '0;
            state_r <= U_DIV;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        // restoring division, one quotient bit a cycle
        U_DIV: begin
          rem_r  <= ge ? DIFF_W'(shifted - {1'b0, div_r}) : shifted[DIFF_W-1:0];
          quo_r  <= {quo_r[PROD_W-2:0], ge};
          prod_r <= prod_r << 1;
          if (cnt_r == CW'(PROD_W - 1)) state_r <= U_FIN;
          else cnt_r <= cnt_r + 1'b1;
        end
        U_FIN: begin
          rsp_r.done <= 1'b1;
          if (quo_r > {{(PROD_W-ENTRY_W){1'b0}}, ENTRY_MAX}) begin
            rsp_r.ovf <= 1'b1;
            rsp_r.q   <= ENTRY_MAX;
          end else begin
            rsp_r.ovf <= 1'b0;
            rsp_r.q   <= quo_r[ENTRY_W-1:0];
          end
          state_r <= U_IDLE;
        end
        default: state_r <= U_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/lagrange_diff_matrix_core.sv
// Lagrange differentiation matrix generator.
// Input: one node position (signed Q3.28) per transfer on in_node_position,
// taken at a clock edge where start is high and busy is low. Nodes are
// stored in a small synchronous node memory in arrival order.
// After the NODES-th node busy goes high and the core emits the NODES x NODES
// matrix in row-major order, one entry per out_valid pulse, with row and
// column index, the signed entry (ENTRY_FRAC_BITS fraction bits, 48 bits),
// a saturation flag and last_entry on the final entry. busy falls after the
// last entry and the next run starts with the next node.
// Each entry is built on one shared multiply-divide unit; a call runs 33
// multiply steps and 81 divide steps between request and result. A diagonal
// entry needs up to NODES-1 calls, an off-diagonal one up to NODES-1 calls
// plus a pass over the nodes. While idle, the core takes a node at every
// clock edge where start is high.
// Every result is shown for exactly one cycle; the receiver cannot stall.
// Reset (synchronous, rst_n low) clears the node count and the sequencer.
module lagrange_diff_matrix_core #(
  parameter int NODES           = ldm_pkg::NODES_DEF,
  parameter int ENTRY_FRAC_BITS = ldm_pkg::EFB_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [ldm_pkg::NODE_W-1:0]  in_node_position,
  output logic                        out_valid,
  output logic [1:0]                  out_row_index,
  output logic [1:0]                  out_column_index,
  output logic [ldm_pkg::ENTRY_W-1:0] out_entry_value,
  output logic                        out_saturated,
  output logic                        out_last_entry
);
  import ldm_pkg::*;

  localparam int IW = $clog2(NODES);
  localparam logic [IW-1:0] LAST = IW'(NODES - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RI, S_RJ, S_PRE, S_KRD, S_KUSE, S_WAIT, S_KEND, S_NEXT
  } state_t;
  typedef enum logic [1:0] {PH_DIAG, PH_PRE, PH_RCP, PH_MUL} phase_t;

  logic [NODE_W-1:0] node_mem [NODES];
  logic [NODE_W-1:0] rdata_r;
  logic [IW-1:0]     raddr;

  state_t             state_r, state_nxt;
  phase_t             phase_r, phase_nxt;
  logic [IW-1:0]      cnt_r, cnt_nxt;
  logic [IW-1:0]      i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic signed [NODE_W-1:0] xi_r, xi_nxt, xj_r, xj_nxt;
  logic [ENTRY_W-1:0] acc_r, acc_nxt, m_r, m_nxt;
  logic               coin_r, coin_nxt, sat_r, sat_nxt, neg_r, neg_nxt;
  md_req_t            req_r, req_nxt;
  md_rsp_t            rsp;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         row_r, row_nxt, col_r, col_nxt;
  logic [ENTRY_W-1:0] val_r, val_nxt;
  logic               osat_r, osat_nxt, olast_r, olast_nxt;

  logic                     accept;
  logic signed [DIFF_W-1:0] xk, d_ik, d_jk, d_ji;
  logic [DIFF_W-1:0]        mag_ik, mag_jk, mag_ji;
  logic                     skip;
  logic signed [ENTRY_W-1:0] term;
  logic signed [ENTRY_W:0]   sum;
  logic [IW+1:0]            i_ext, j_ext;

  ldm_muldiv u_md (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_r),
    .rsp   (rsp)
  );

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  always_comb begin
    case (state_r)
      S_RI:    raddr = i_r;
      S_RJ:    raddr = j_r;
      default: raddr = k_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) node_mem[cnt_r] <= in_node_position;
    rdata_r <= node_mem[raddr];
  end

  assign xk     = DIFF_W'($signed(rdata_r));
  assign d_ik   = DIFF_W'(xi_r) - xk;
  assign d_jk   = DIFF_W'(xj_r) - xk;
  assign d_ji   = DIFF_W'(xj_r) - DIFF_W'(xi_r);
  assign mag_ik = d_ik[DIFF_W-1] ? DIFF_W'(-d_ik) : d_ik;
  assign mag_jk = d_jk[DIFF_W-1] ? DIFF_W'(-d_jk) : d_jk;
  assign mag_ji = d_ji[DIFF_W-1] ? DIFF_W'(-d_ji) : d_ji;
  assign skip   = (k_r == i_r) || ((phase_r != PH_DIAG) && (k_r == j_r));
  assign i_ext  = {2'b00, i_r};
  assign j_ext  = {2'b00, j_r};

  // diagonal term from the reciprocal in rsp; d_ik is held by xk in rdata_r
  always_comb begin
    if (rsp.ovf) term = d_ik[DIFF_W-1] ? $signed(ENTRY_MIN) : $signed(ENTRY_MAX);
    else term = d_ik[DIFF_W-1] ? $signed(ENTRY_W'(-rsp.q)) : $signed(rsp.q);
    sum = $signed({acc_r[ENTRY_W-1], acc_r}) + $signed({term[ENTRY_W-1], term});
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    xi_nxt        = xi_r;
    xj_nxt        = xj_r;
    acc_nxt       = acc_r;
    m_nxt         = m_r;
    coin_nxt      = coin_r;
    sat_nxt       = sat_r;
    neg_nxt       = neg_r;
    req_nxt       = req_r;
    req_nxt.start = 1'b0;
    out_valid_nxt = 1'b0;
    row_nxt       = row_r;
    col_nxt       = col_r;
    val_nxt       = val_r;
    osat_nxt      = osat_r;
    olast_nxt     = olast_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (cnt_r == LAST) begin
            cnt_nxt   = '0;
            i_nxt     = '0;
            j_nxt     = '0;
            state_nxt = S_RI;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      S_RI: state_nxt = S_RJ;
      S_RJ: begin
        xi_nxt    = rdata_r;
        state_nxt = S_PRE;
      end
      S_PRE: begin
        xj_nxt   = rdata_r;
        k_nxt    = '0;
        acc_nxt  = '0;
        coin_nxt = 1'b0;
        sat_nxt  = 1'b0;
        if (i_r == j_r) begin
          phase_nxt = PH_DIAG;
          state_nxt = S_KRD;
        end else begin
          phase_nxt = PH_PRE;
          state_nxt = S_KRD;
        end
      end
      S_KRD: begin
        if (phase_r == PH_PRE && k_r == '0 && d_ji == '0) begin
          // coincident pair i, j
          val_nxt = ENTRY_MAX; osat_nxt = 1'b1; state_nxt = S_NEXT;
          out_valid_nxt = 1'b1;
        end else if (phase_r == PH_PRE && k_r == '0) begin
          neg_nxt = d_ji[DIFF_W-1];
          if (skip) begin
            if (k_r == LAST) state_nxt = S_KEND;
            else k_nxt = k_r + 1'b1;
          end else begin
            state_nxt = S_KUSE;
          end
        end else if (skip) begin
          if (k_r == LAST) state_nxt = S_KEND;
          else k_nxt = k_r + 1'b1;
        end else begin
          state_nxt = S_KUSE;
        end
      end
      S_KUSE: begin
        case (phase_r)
          PH_DIAG: begin
            if (d_ik == '0) begin
              coin_nxt = 1'b1;
              if (k_r == LAST) state_nxt = S_KEND;
              else begin k_nxt = k_r + 1'b1; state_nxt = S_KRD; end
            end else begin
              req_nxt.start = 1'b1;
              req_nxt.m     = ENTRY_W'(64'd1 << ENTRY_FRAC_BITS);
              req_nxt.a     = DIFF_W'(64'd1 << NODE_FRAC_BITS);
              req_nxt.b     = mag_ik;
              state_nxt     = S_WAIT;
            end
          end
          PH_PRE: begin
            if (d_jk == '0) begin
              val_nxt = ENTRY_MAX; osat_nxt = 1'b1; out_valid_nxt = 1'b1;
              state_nxt = S_NEXT;
            end else begin
              neg_nxt = neg_r ^ d_ik[DIFF_W-1] ^ d_jk[DIFF_W-1];
              if (k_r == LAST) state_nxt = S_KEND;
              else begin k_nxt = k_r + 1'b1; state_nxt = S_KRD; end
            end
          end
          default: begin
            req_nxt.start = 1'b1;
            req_nxt.m     = m_r;
            req_nxt.a     = mag_ik;
            req_nxt.b     = mag_jk;
            state_nxt     = S_WAIT;
          end
        endcase
      end
      S_WAIT: begin
        if (rsp.done) begin
          case (phase_r)
            PH_DIAG: begin
              if (rsp.ovf) sat_nxt = 1'b1;
              if (sum > $signed({ENTRY_MAX[ENTRY_W-1], ENTRY_MAX})) begin
                acc_nxt = ENTRY_MAX; sat_nxt = 1'b1;
              end else if (sum < $signed({ENTRY_MIN[ENTRY_W-1], ENTRY_MIN})) begin
                acc_nxt = ENTRY_MIN; sat_nxt = 1'b1;
              end else begin
                acc_nxt = sum[ENTRY_W-1:0];
              end
              if (k_r == LAST) state_nxt = S_KEND;
              else begin k_nxt = k_r + 1'b1; state_nxt = S_KRD; end
            end
            default: begin
              m_nxt = rsp.q;
              if (rsp.ovf) begin
                val_nxt  = neg_r ? ENTRY_MIN : ENTRY_MAX;
                osat_nxt = 1'b1; out_valid_nxt = 1'b1;
                state_nxt = S_NEXT;
              end else if (phase_r == PH_RCP) begin
                phase_nxt = PH_MUL; k_nxt = '0; state_nxt = S_KRD;
              end else if (k_r == LAST) begin
                state_nxt = S_KEND;
              end else begin
                k_nxt = k_r + 1'b1; state_nxt = S_KRD;
              end
            end
          endcase
        end
      end
      S_KEND: begin
        case (phase_r)
          PH_DIAG: begin
            val_nxt  = coin_r ? ENTRY_MAX : acc_r;
            osat_nxt = coin_r || sat_r;
            out_valid_nxt = 1'b1;
            state_nxt = S_NEXT;
          end
          PH_PRE: begin
            req_nxt.start = 1'b1;
            req_nxt.m     = ENTRY_W'(64'd1 << ENTRY_FRAC_BITS);
            req_nxt.a     = DIFF_W'(64'd1 << NODE_FRAC_BITS);
            req_nxt.b     = mag_ji;
            phase_nxt     = PH_RCP;
            state_nxt     = S_WAIT;
          end
          default: begin
            val_nxt  = neg_r ? ENTRY_W'(-m_r) : m_r;
            osat_nxt = 1'b0;
            out_valid_nxt = 1'b1;
            state_nxt = S_NEXT;
          end
        endcase
        row_nxt   = i_ext[1:0];
        col_nxt   = j_ext[1:0];
        olast_nxt = (i_r == LAST) && (j_r == LAST);
      end
      S_NEXT: begin
        if (j_r == LAST) begin
          j_nxt = '0;
          if (i_r == LAST) state_nxt = S_IDLE;
          else begin i_nxt = i_r + 1'b1; state_nxt = S_RI; end
        end else begin
          j_nxt = j_r + 1'b1;
          state_nxt = S_RI;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // early exits leave from S_KRD, S_KUSE or S_WAIT: tag the entry there too
    if (out_valid_nxt && state_r != S_KEND) begin
      row_nxt   = i_ext[1:0];
      col_nxt   = j_ext[1:0];
      olast_nxt = (i_r == LAST) && (j_r == LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cnt_r         <= '0;
      req_r.start   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      req_r         <= req_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    phase_r <= phase_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    k_r     <= k_nxt;
    xi_r    <= xi_nxt;
    xj_r    <= xj_nxt;
    acc_r   <= acc_nxt;
    m_r     <= m_nxt;
    coin_r  <= coin_nxt;
    sat_r   <= sat_nxt;
    neg_r   <= neg_nxt;
    row_r   <= row_nxt;
    col_r   <= col_nxt;
    val_r   <= val_nxt;
    osat_r  <= osat_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_row_index    = row_r;
  assign out_column_index = col_r;
  assign out_entry_value  = val_r;
  assign out_saturated    = osat_r;
  assign out_last_entry   = olast_r;

endmodule
